// ----- design/stf_pkg.sv -----
// ----------------------------------------------------------------------------
// stf_pkg: shared types and constants for the similarity transform fit block
// Payload structs, status codes, controller/datapath command and the MAC
// microprogram used for the closed-form solve.
// ----------------------------------------------------------------------------
package stf_pkg;

	typedef struct packed {
		logic [15:0] template_x;
		logic [15:0] template_y;
		logic [15:0] scene_x;
		logic [15:0] scene_y;
		logic        last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] scale_cos;
		logic signed [31:0] scale_sin;
		logic signed [23:0] shift_x;
		logic signed [23:0] shift_y;
		logic [1:0]         fit_status;
	} result_t;

	typedef enum logic [1:0] {
		FIT_OK         = 2'd0,
		FIT_DEGENERATE = 2'd1,
		FIT_OVERFLOW   = 2'd2
	} fit_status_t;

	// multiplier A operand
	typedef enum logic [2:0] {
		A_N, A_SX, A_SY, A_A1, A_A2, A_K16
	} a_sel_t;

	// multiplier B operand
	typedef enum logic [3:0] {
		B_PXX, B_PYY, B_PXXD, B_PXYD, B_PYXD, B_PYYD, B_SX, B_SY, B_SXD, B_SYD
	} b_sel_t;

	// where the accumulator lands at the end of a term group
	typedef enum logic [1:0] {
		DST_NONE, DST_DEN, DST_NUM1, DST_NUM2
	} dst_t;

	// division jobs
	typedef enum logic [1:0] {
		DIV_A1, DIV_A2, DIV_A3, DIV_A4
	} div_sel_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic   neg;
		logic   first;
		dst_t   dst;
	} mac_op_t;

	localparam int STEP_W       = 5;
	localparam logic [STEP_W-1:0] STEP_END_1 = 5'd11;
	localparam logic [STEP_W-1:0] STEP_END_2 = 5'd17;

	typedef struct packed {
		logic              accum;
		logic              mac_en;
		logic              hi;
		logic [STEP_W-1:0] step;
		logic              div_start;
		div_sel_t          div_sel;
		logic              finish;
		fit_status_t       status;
	} stf_cmd_t;

	typedef struct packed {
		logic ovf;
		logic den_le0;
		logic div_done;
	} stf_sts_t;

	// D, N1, N2, then the two translation numerators
	function automatic mac_op_t mac_op(input logic [STEP_W-1:0] step);
		mac_op_t op;
		case (step)
			5'd0:    op = '{A_N,   B_PXX,  1'b0, 1'b1, DST_NONE};
			5'd1:    op = '{A_N,   B_PYY,  1'b0, 1'b0, DST_NONE};
			5'd2:    op = '{A_SX,  B_SX,   1'b1, 1'b0, DST_NONE};
			5'd3:    op = '{A_SY,  B_SY,   1'b1, 1'b0, DST_DEN};
			5'd4:    op = '{A_N,   B_PXXD, 1'b0, 1'b1, DST_NONE};
			5'd5:    op = '{A_N,   B_PYYD, 1'b0, 1'b0, DST_NONE};
			5'd6:    op = '{A_SX,  B_SXD,  1'b1, 1'b0, DST_NONE};
			5'd7:    op = '{A_SY,  B_SYD,  1'b1, 1'b0, DST_NUM1};
			5'd8:    op = '{A_N,   B_PXYD, 1'b0, 1'b1, DST_NONE};
			5'd9:    op = '{A_N,   B_PYXD, 1'b1, 1'b0, DST_NONE};
			5'd10:   op = '{A_SX,  B_SYD,  1'b1, 1'b0, DST_NONE};
			5'd11:   op = '{A_SY,  B_SXD,  1'b0, 1'b0, DST_NUM2};
			5'd12:   op = '{A_K16, B_SXD,  1'b0, 1'b1, DST_NONE};
			5'd13:   op = '{A_A1,  B_SX,   1'b1, 1'b0, DST_NONE};
			5'd14:   op = '{A_A2,  B_SY,   1'b0, 1'b0, DST_NUM1};
			5'd15:   op = '{A_K16, B_SYD,  1'b0, 1'b1, DST_NONE};
			5'd16:   op = '{A_A2,  B_SX,   1'b1, 1'b0, DST_NONE};
			5'd17:   op = '{A_A1,  B_SY,   1'b1, 1'b0, DST_NUM2};
			default: op = '{A_N,   B_PXX,  1'b0, 1'b0, DST_NONE};
		endcase
		return op;
	endfunction

endpackage

// ----- design/stf_div.sv -----
// ----------------------------------------------------------------------------
// stf_div: unsigned restoring divider
// One quotient bit per cycle, done pulses once per division.
// ----------------------------------------------------------------------------
module stf_div import stf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [79:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [79:0] quotient
);

	logic [79:0] dvd_q;
	logic [63:0] rem_q;
	logic [63:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [64:0] shifted;
	logic        fits;

	assign shifted = {rem_q, dvd_q[79]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd80;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? 64'(shifted - {1'b0, dsr_q}) : shifted[63:0];
			dvd_q <= {dvd_q[78:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- design/stf_dp.sv -----
// ----------------------------------------------------------------------------
// stf_dp: datapath
// Running sums, shared multiply-accumulate, divider and result register.
// ----------------------------------------------------------------------------
module stf_dp import stf_pkg::*; #(
	parameter int MAX_POINTS      = 1024,
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  point_t   point,
	input  stf_cmd_t cmd,
	output stf_sts_t sts,
	output logic     done,
	output result_t  result
);

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SW  = 16 + CW;
	localparam int PW  = 32 + CW;
	localparam int TSH = 12 + COORD_FRAC_BITS;

	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic [SW-1:0] sx_q, sy_q, sxd_q, syd_q;
	logic [PW-1:0] pxx_q, pyy_q, pxxd_q, pxyd_q, pyxd_q, pyyd_q;
	logic [31:0]   m_xx, m_yy, m_xxd, m_xyd, m_yxd, m_yyd;

	logic signed [63:0] acc_q, den_q, num1_q, num2_q;
	logic signed [31:0] a1_q, a2_q;
	logic signed [23:0] a3_q, a4_q;
	div_sel_t           dsel_q;
	logic               neg_q;
	logic               done_q;
	result_t            res_q;

	mac_op_t            op;
	logic signed [32:0] a_op;
	logic [63:0]        b_op;
	logic signed [32:0] b_part;
	logic signed [65:0] prod;
	logic signed [63:0] p64, base, acc_d;

	logic signed [63:0] dnum;
	logic [63:0]        dden, dmag;
	logic [79:0]        dvd;
	logic               dwait;
	logic [79:0]        quot;
	logic               div_done;
	logic signed [31:0] rnd_w, rnd_n;

	// (q+1)/2 with sign, saturated to 32 or 24 bits
	function automatic logic signed [31:0] round_sat(input logic [79:0] q, input logic neg,
		input logic wide);
		logic [80:0] m;
		logic [80:0] hi;
		m  = ({1'b0, q} + 81'd1) >> 1;
		hi = wide ? 81'h7FFF_FFFF : 81'h7F_FFFF;
		if (!neg)
			return (m > hi) ? 32'(hi) : 32'(m);
		else
			return (m > hi + 81'd1) ? -32'(hi + 81'd1) : -32'(m);
	endfunction

	// ---------------- accumulation ----------------
	// full 32-bit pair products
	assign m_xx  = point.template_x * point.template_x;
	assign m_yy  = point.template_y * point.template_y;
	assign m_xxd = point.template_x * point.scene_x;
	assign m_xyd = point.template_x * point.scene_y;
	assign m_yxd = point.template_y * point.scene_x;
	assign m_yyd = point.template_y * point.scene_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			ovf_q <= 1'b0;
			sx_q  <= '0; sy_q <= '0; sxd_q <= '0; syd_q <= '0;
			pxx_q <= '0; pyy_q <= '0; pxxd_q <= '0; pxyd_q <= '0; pyxd_q <= '0; pyyd_q <= '0;
		end else if (cmd.finish) begin
			n_q   <= '0;
			ovf_q <= 1'b0;
			sx_q  <= '0; sy_q <= '0; sxd_q <= '0; syd_q <= '0;
			pxx_q <= '0; pyy_q <= '0; pxxd_q <= '0; pxyd_q <= '0; pyxd_q <= '0; pyyd_q <= '0;
		end else if (cmd.accum) begin
			if (n_q >= CW'(MAX_POINTS)) begin
				ovf_q <= 1'b1;
			end else begin
				n_q    <= n_q + CW'(1);
				sx_q   <= sx_q  + SW'(point.template_x);
				sy_q   <= sy_q  + SW'(point.template_y);
				sxd_q  <= sxd_q + SW'(point.scene_x);
				syd_q  <= syd_q + SW'(point.scene_y);
				pxx_q  <= pxx_q  + PW'(m_xx);
				pyy_q  <= pyy_q  + PW'(m_yy);
				pxxd_q <= pxxd_q + PW'(m_xxd);
				pxyd_q <= pxyd_q + PW'(m_xyd);
				pyxd_q <= pyxd_q + PW'(m_yxd);
				pyyd_q <= pyyd_q + PW'(m_yyd);
			end
		end
	end

	// ---------------- multiply-accumulate, B in two 32-bit halves ----------------
	always_comb begin
		op = mac_op(cmd.step);
		case (op.a_sel)
			A_N:     a_op = 33'(n_q);
			A_SX:    a_op = 33'(sx_q);
			A_SY:    a_op = 33'(sy_q);
			A_A1:    a_op = 33'(a1_q);
			A_A2:    a_op = 33'(a2_q);
			A_K16:   a_op = 33'sd65536;
			default: a_op = '0;
		endcase
		case (op.b_sel)
			B_PXX:   b_op = 64'(pxx_q);
			B_PYY:   b_op = 64'(pyy_q);
			B_PXXD:  b_op = 64'(pxxd_q);
			B_PXYD:  b_op = 64'(pxyd_q);
			B_PYXD:  b_op = 64'(pyxd_q);
			B_PYYD:  b_op = 64'(pyyd_q);
			B_SX:    b_op = 64'(sx_q);
			B_SY:    b_op = 64'(sy_q);
			B_SXD:   b_op = 64'(sxd_q);
			B_SYD:   b_op = 64'(syd_q);
			default: b_op = '0;
		endcase
		b_part = cmd.hi ? $signed({b_op[63], b_op[63:32]}) : $signed({1'b0, b_op[31:0]});
		prod   = a_op * b_part;
		p64    = cmd.hi ? $signed({prod[31:0], 32'd0}) : prod[63:0];
		base   = (op.first && !cmd.hi) ? 64'sd0 : acc_q;
		acc_d  = op.neg ? base - p64 : base + p64;
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			acc_q <= acc_d;
			if (cmd.hi) begin
				case (op.dst)
					DST_DEN:  den_q  <= acc_d;
					DST_NUM1: num1_q <= acc_d;
					DST_NUM2: num2_q <= acc_d;
					default:  ;
				endcase
			end
		end
	end

	// ---------------- division jobs ----------------
	always_comb begin
		case (cmd.div_sel)
			DIV_A1:  begin dnum = num1_q; dden = den_q; end
			DIV_A2:  begin dnum = num2_q; dden = den_q; end
			DIV_A3:  begin dnum = num1_q; dden = 64'(n_q) << TSH; end
			DIV_A4:  begin dnum = num2_q; dden = 64'(n_q) << TSH; end
			default: begin dnum = num1_q; dden = den_q; end
		endcase
		dmag  = dnum[63] ? 64'(-dnum) : 64'(dnum);
		dwait = (cmd.div_sel == DIV_A1) || (cmd.div_sel == DIV_A2);
		dvd   = dwait ? {dmag[62:0], 17'd0} : {15'd0, dmag, 1'b0};
	end

	stf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dden),
		.done     (div_done),
		.quotient (quot)
	);

	assign rnd_w = round_sat(quot, neg_q, 1'b1);
	assign rnd_n = round_sat(quot, neg_q, 1'b0);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dsel_q <= cmd.div_sel;
			neg_q  <= dnum[63];
		end
		if (div_done) begin
			case (dsel_q)
				DIV_A1:  a1_q <= rnd_w;
				DIV_A2:  a2_q <= rnd_w;
				DIV_A3:  a3_q <= rnd_n[23:0];
				DIV_A4:  a4_q <= rnd_n[23:0];
				default: ;
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.fit_status <= cmd.status;
			if (cmd.status == FIT_OK) begin
				res_q.scale_cos <= a1_q;
				res_q.scale_sin <= a2_q;
				res_q.shift_x   <= a3_q;
				res_q.shift_y   <= a4_q;
			end else begin
				res_q.scale_cos <= '0;
				res_q.scale_sin <= '0;
				res_q.shift_x   <= '0;
				res_q.shift_y   <= '0;
			end
		end
	end

	assign sts.ovf      = ovf_q;
	assign sts.den_le0  = (den_q <= 64'sd0);
	assign sts.div_done = div_done;
	assign done         = done_q;
	assign result       = res_q;

endmodule

// ----- design/stf_ctrl.sv -----
// ----------------------------------------------------------------------------
// stf_ctrl: controller
// Sequences accumulation, the MAC microprogram, four divisions and output.
// ----------------------------------------------------------------------------
module stf_ctrl import stf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     last,
	input  stf_sts_t sts,
	output stf_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_START  = 11'b000_0000_0010,
		S_MAC1   = 11'b000_0000_0100,
		S_CHK    = 11'b000_0000_1000,
		S_DIV1   = 11'b000_0001_0000,
		S_DIV2   = 11'b000_0010_0000,
		S_MAC2   = 11'b000_0100_0000,
		S_LAUNCH = 11'b000_1000_0000,
		S_DIV3   = 11'b001_0000_0000,
		S_DIV4   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              hi_q, hi_d;
	fit_status_t       status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			hi_q     <= 1'b0;
			status_q <= FIT_OK;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			hi_q     <= hi_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		hi_d     = hi_q;
		status_d = status_q;
		cmd      = '0;
		cmd.step    = step_q;
		cmd.hi      = hi_q;
		cmd.status  = status_q;
		cmd.div_sel = DIV_A1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accum = 1'b1;
					if (last)
						state_d = S_START;
				end
			end
			S_START: begin
				step_d = '0;
				hi_d   = 1'b0;
				if (sts.ovf) begin
					status_d = FIT_OVERFLOW;
					state_d  = S_DONE;
				end else begin
					state_d = S_MAC1;
				end
			end
			S_MAC1, S_MAC2: begin
				cmd.mac_en = 1'b1;
				hi_d       = !hi_q;
				if (hi_q) begin
					step_d = step_q + STEP_W'(1);
					if (state_q == S_MAC1 && step_q == STEP_END_1)
						state_d = S_CHK;
					if (state_q == S_MAC2 && step_q == STEP_END_2)
						state_d = S_LAUNCH;
				end
			end
			S_CHK: begin
				if (sts.den_le0) begin
					status_d = FIT_DEGENERATE;
					state_d  = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_A1;
					state_d       = S_DIV1;
				end
			end
			S_DIV1: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_A2;
					state_d       = S_DIV2;
				end
			end
			S_DIV2: begin
				if (sts.div_done)
					state_d = S_MAC2;
			end
			S_LAUNCH: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_A3;
				state_d       = S_DIV3;
			end
			S_DIV3: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_A4;
					state_d       = S_DIV4;
				end
			end
			S_DIV4: begin
				if (sts.div_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				status_d   = FIT_OK;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- design/similarity_transform_fit_top.sv -----
// ----------------------------------------------------------------------------
// similarity_transform_fit_top: least-squares 2D similarity transform fit
// Accumulates matched point pairs and solves rotation-scale and translation
// on the pair marked last.
// ----------------------------------------------------------------------------
//
//  channel | ports                  | transfer when
//  --------+------------------------+-----------------------------
//  point   | start, busy, point     | start high while busy low
//  result  | done, result           | done high (one cycle, no stall)
//
// A pair that is not last is absorbed as it is taken; busy stays low, so
// pairs may follow back to back.
// A last pair starts the solve: a setup state, MAC steps for D, N1, N2
// (one 33x33 multiplier, B operand in two halves), a check state, 2 divisions,
// MAC steps for the translation numerators, a launch state, 2 more
// divisions and a finish state; busy stays high throughout.
// Overflowed or degenerate sets finish early. done follows in the next cycle.
// Reset (arst_n low) clears the sums, the count and the controller.
// The receiver cannot stall; done is high for exactly one cycle and result holds until the next finish.
// ----------------------------------------------------------------------------
module similarity_transform_fit_top import stf_pkg::*; #(
	parameter int MAX_POINTS      = 1024,
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  point_t  point,
	output logic    done,
	output result_t result
);

	stf_cmd_t cmd;
	stf_sts_t sts;

	// sequencing
	stf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (point.last_point),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// sums, MAC, divider, result register
	stf_dp #(
		.MAX_POINTS      (MAX_POINTS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
